// ===== hdl/pfr_pkg.sv =====
// ----------------------------------------------------------------------------
// pfr_pkg: shared definitions for the packet frame ring
// Operation and status codes, field widths, parameter defaults, result type.
// ----------------------------------------------------------------------------
`default_nettype none

package pfr_pkg;

  localparam int RING_SLOTS_DEF  = 16;
  localparam int FRAME_BYTES_DEF = 2048;

  localparam int OP_W      = 2;
  localparam int LEN_IN_W  = 16;
  localparam int BYTE_W    = 8;
  localparam int LEN_OUT_W = 12;
  localparam int ST_W      = 3;

  typedef enum logic [OP_W-1:0] {
    OP_BEGIN = 2'd0,
    OP_DATA  = 2'd1,
    OP_POP   = 2'd2,
    OP_NONE  = 2'd3
  } pfr_op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 3'd0,
    ST_OVERFLOW = 3'd1,
    ST_FULL     = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_NOPUSH   = 3'd4
  } pfr_status_t;

  typedef struct packed {
    pfr_status_t            status;
    logic [BYTE_W-1:0]      data_byte;
    logic [LEN_OUT_W-1:0]   frame_length;
    logic                   last;
  } pfr_result_t;

endpackage

`default_nettype wire

// ===== hdl/pfr_in_if.sv =====
// ----------------------------------------------------------------------------
// pfr_in_if: command channel of the packet frame ring
// Valid/ready channel carrying one operation word per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface pfr_in_if import pfr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     operation;
  logic [LEN_IN_W-1:0] frame_length_in;
  logic [BYTE_W-1:0]   data_byte_in;

  modport source (output valid, operation, frame_length_in, data_byte_in, input ready);
  modport sink   (input valid, operation, frame_length_in, data_byte_in, output ready);
endinterface

`default_nettype wire

// ===== hdl/pfr_out_if.sv =====
// ----------------------------------------------------------------------------
// pfr_out_if: result channel of the packet frame ring
// Valid/ready channel carrying one result word per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface pfr_out_if import pfr_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [ST_W-1:0]      status;
  logic [BYTE_W-1:0]    data_byte_out;
  logic [LEN_OUT_W-1:0] frame_length_out;
  logic                 last;

  modport source (output valid, status, data_byte_out, frame_length_out, last, input ready);
  modport sink   (input valid, status, data_byte_out, frame_length_out, last, output ready);
endinterface

`default_nettype wire

// ===== hdl/pfr_ram.sv =====
// ----------------------------------------------------------------------------
// pfr_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/pfr_ctrl.sv =====
// ----------------------------------------------------------------------------
// pfr_ctrl: ring control and frame storage
// Holds head, tail and offsets, and the length and byte memories.
// ----------------------------------------------------------------------------
`default_nettype none

module pfr_ctrl import pfr_pkg::*; #(
  parameter int RING_SLOTS  = RING_SLOTS_DEF,
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [OP_W-1:0]     operation,
  input  wire logic [LEN_IN_W-1:0] frame_length_in,
  input  wire logic [BYTE_W-1:0]   data_byte_in,
  input  wire logic                room,
  output logic                     res_valid,
  output pfr_result_t              res
);

  localparam int IDX_W  = $clog2(RING_SLOTS);
  localparam int LEN_W  = $clog2(FRAME_BYTES + 1);
  localparam int DEPTH  = RING_SLOTS * FRAME_BYTES;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam logic [IDX_W-1:0]    LAST_SLOT = IDX_W'(RING_SLOTS - 1);
  localparam logic [LEN_IN_W-1:0] MAX_LEN   = LEN_IN_W'(FRAME_BYTES);
  localparam logic [ADDR_W-1:0]   SLOT_SPAN = ADDR_W'(FRAME_BYTES);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [LEN_W-1:0] wo_r, wo_nxt, ro_r, ro_nxt, plen_r, plen_nxt;
  logic             open_r, open_nxt;

  logic              acc;
  logic [IDX_W-1:0]  head_adv, tail_adv;
  logic [LEN_W-1:0]  wo_inc, ro_new;
  logic              len_we, byte_we, mem_re;
  logic [LEN_W-1:0]  len_wd, len_q;
  logic [BYTE_W-1:0] byte_q;
  logic [ADDR_W-1:0] byte_waddr, byte_raddr;

  assign in_ready = (state_r == S_IDLE) && room;
  assign acc      = in_valid && in_ready;

  assign head_adv = (head_r == LAST_SLOT) ? '0 : head_r + 1'b1;
  assign tail_adv = (tail_r == LAST_SLOT) ? '0 : tail_r + 1'b1;
  assign wo_inc   = wo_r + 1'b1;

  // Slot base is a product by a constant, then the byte offset is added.
  assign byte_waddr = ADDR_W'(head_r) * SLOT_SPAN + ADDR_W'(wo_r);
  assign byte_raddr = ADDR_W'(tail_r) * SLOT_SPAN + ADDR_W'(ro_r);
  assign mem_re     = acc && (operation == OP_POP);

  pfr_ram #(.WIDTH(LEN_W), .DEPTH(RING_SLOTS)) u_len_ram (
    .clk   (clk),
    .we    (len_we),
    .waddr (head_r),
    .wdata (len_wd),
    .re    (mem_re),
    .raddr (tail_r),
    .rdata (len_q)
  );

  pfr_ram #(.WIDTH(BYTE_W), .DEPTH(DEPTH)) u_byte_ram (
    .clk   (clk),
    .we    (byte_we),
    .waddr (byte_waddr),
    .wdata (data_byte_in),
    .re    (mem_re),
    .raddr (byte_raddr),
    .rdata (byte_q)
  );

  always_comb begin
    state_nxt = state_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    wo_nxt    = wo_r;
    ro_nxt    = ro_r;
    plen_nxt  = plen_r;
    open_nxt  = open_r;
    len_we    = 1'b0;
    len_wd    = plen_r;
    byte_we   = 1'b0;
    ro_new    = ro_r;
    res_valid = 1'b0;
    res       = '{status: ST_OK, data_byte: '0, frame_length: '0, last: 1'b0};

    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          unique case (operation)
            OP_BEGIN: begin
              res_valid = 1'b1;
              if (frame_length_in > MAX_LEN) begin
                res.status = ST_OVERFLOW;
              end else if (head_adv == tail_r) begin
                res.status = ST_FULL;
              end else begin
                plen_nxt = frame_length_in[LEN_W-1:0];
                wo_nxt   = '0;
                open_nxt = 1'b1;
                if (frame_length_in == '0) begin
                  // Empty frame commits at once.
                  len_we   = 1'b1;
                  len_wd   = '0;
                  head_nxt = head_adv;
                  open_nxt = 1'b0;
                end
              end
            end
            OP_DATA: begin
              res_valid = 1'b1;
              if (!open_r) begin
                res.status = ST_NOPUSH;
              end else begin
                byte_we = 1'b1;
                wo_nxt  = wo_inc;
                if (wo_inc >= plen_r) begin
                  len_we   = 1'b1;
                  len_wd   = plen_r;
                  head_nxt = head_adv;
                  open_nxt = 1'b0;
                  wo_nxt   = '0;
                end
              end
            end
            OP_POP: begin
              state_nxt = S_READ;
            end
            OP_NONE: begin
              res_valid = 1'b1;
            end
            default: begin
              res_valid = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        // Length and byte memories return the tail slot data here.
        res_valid = 1'b1;
        state_nxt = S_IDLE;
        if (head_r == tail_r) begin
          res.status = ST_EMPTY;
        end else begin
          res.frame_length = LEN_OUT_W'(len_q);
          if (len_q != '0) begin
            res.data_byte = byte_q;
            ro_new        = ro_r + 1'b1;
          end
          ro_nxt = ro_new;
          if (ro_new >= len_q) begin
            res.last = 1'b1;
            ro_nxt   = '0;
            tail_nxt = tail_adv;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      tail_r  <= '0;
      wo_r    <= '0;
      ro_r    <= '0;
      plen_r  <= '0;
      open_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      wo_r    <= wo_nxt;
      ro_r    <= ro_nxt;
      plen_r  <= plen_nxt;
      open_r  <= open_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/pfr_outq.sv =====
// ----------------------------------------------------------------------------
// pfr_outq: two-word result queue
// Decouples the result channel from the control so a stall blocks only once it is full.
// ----------------------------------------------------------------------------
`default_nettype none

module pfr_outq import pfr_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         wr_en,
  input  wire pfr_result_t  wr_data,
  output logic              room,
  output logic              out_valid,
  input  wire logic         out_ready,
  output pfr_result_t       out_data
);

  pfr_result_t q_r [2];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        rd_en;

  assign out_valid = (cnt_r != 2'd0);
  assign room      = (cnt_r != 2'd2);
  assign rd_en     = out_valid && out_ready;
  assign out_data  = q_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!wr_en && rd_en) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_r[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (wr_en) begin
        wp_r <= ~wp_r;
      end
      if (rd_en) begin
        rp_r <= ~rp_r;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/packet_frame_ring.sv =====
// ----------------------------------------------------------------------------
// packet_frame_ring: ring buffer of whole-frame slots
// Frames are pushed as a begin word plus data bytes and popped byte by byte.
// ----------------------------------------------------------------------------
// Usage:
// The in_ch channel takes one command word per handshake: a begin word with
// the frame length, a data word carrying one frame byte, or a pop word. Every
// command word yields exactly one result word on out_ch, in order: a status,
// the popped byte, the stored frame length and a last mark on the final byte.
// One slot of the ring is always kept empty, so RING_SLOTS - 1 frames fit.
// Begin and data words are handled in the cycle they are accepted, so their
// result is registered into the result queue and the next word may follow at once.
// A pop word is handled over the S_IDLE and S_READ states: the length and byte
// memories are read at acceptance and their registered data is used in the
// following cycle, so in_ch.ready is low in the cycle after a pop is accepted.
// Results pass through a two-word queue; when out_ch is stalled the block
// keeps accepting until that queue is full, then holds in_ch.ready low.
// Reset (rst_n low at a clock edge) empties the ring, closes any open push
// and drops queued results. Memory contents are not cleared and need no
// clearing pass: a committed frame only ever exposes bytes that were written.
// ----------------------------------------------------------------------------
`default_nettype none

module packet_frame_ring import pfr_pkg::*; #(
  parameter int RING_SLOTS  = RING_SLOTS_DEF,
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  pfr_in_if.sink   in_ch,
  pfr_out_if.source out_ch
);

  logic        room;
  logic        res_valid;
  pfr_result_t res;
  pfr_result_t out_data;

  // Control and storage: one command in flight at a time.
  pfr_ctrl #(
    .RING_SLOTS  (RING_SLOTS),
    .FRAME_BYTES (FRAME_BYTES)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .operation       (in_ch.operation),
    .frame_length_in (in_ch.frame_length_in),
    .data_byte_in    (in_ch.data_byte_in),
    .room            (room),
    .res_valid       (res_valid),
    .res             (res)
  );

  // Result queue in front of the output channel.
  pfr_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (res_valid),
    .wr_data   (res),
    .room      (room),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_data)
  );

  assign out_ch.status           = out_data.status;
  assign out_ch.data_byte_out    = out_data.data_byte;
  assign out_ch.frame_length_out = out_data.frame_length;
  assign out_ch.last             = out_data.last;

endmodule

`default_nettype wire

// ===== hdl/pfr_chk.sv =====
// ----------------------------------------------------------------------------
// pfr_chk: port-level checks for the packet frame ring
// Watches both channels and flags inconsistent results or handshake slips.
// ----------------------------------------------------------------------------
`default_nettype none

module pfr_chk import pfr_pkg::*; (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_valid,
  input wire logic                 in_ready,
  input wire logic [OP_W-1:0]      in_operation,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire logic [ST_W-1:0]      out_status,
  input wire logic [BYTE_W-1:0]    out_data_byte,
  input wire logic [LEN_OUT_W-1:0] out_frame_length,
  input wire logic                 out_last
);

  // Reset drops every queued result.
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A pop holds in_ready low while it waits on the memory read.
  a_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_operation == OP_POP) |=> !in_ready)
    else $error("command accepted during pop read cycle");

  // Any refusal carries no byte, no length and no last mark.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |->
      (out_data_byte == '0) && (out_frame_length == '0) && !out_last)
    else $error("failed result carries payload");

  // A nonzero byte can only come from a frame with a nonzero length.
  a_byte_has_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data_byte != '0) |-> (out_frame_length != '0))
    else $error("byte popped from an empty frame");

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_status) && $stable(out_data_byte) &&
      $stable(out_frame_length) && $stable(out_last))
    else $error("result changed while stalled");

endmodule

bind packet_frame_ring pfr_chk u_pfr_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .in_operation     (in_ch.operation),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_status       (out_ch.status),
  .out_data_byte    (out_ch.data_byte_out),
  .out_frame_length (out_ch.frame_length_out),
  .out_last         (out_ch.last)
);

`default_nettype wire
